// File: sv/lobt_pkg.sv
// Shared types and codes for the limit order book table.
package lobt_pkg;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_CANCEL = 2'd1;
   localparam logic [1:0] ACT_FILL   = 2'd2;
   localparam logic [1:0] ACT_QUERY  = 2'd3;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_NOT_FOUND = 3'd1;
   localparam logic [2:0] STATUS_DUP_ID    = 3'd2;
   localparam logic [2:0] STATUS_BAD_QTY   = 3'd3;
   localparam logic [2:0] STATUS_FULL      = 3'd4;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] order_id;
      logic        side;
      logic [9:0]  price;
      logic [23:0] quantity;
      logic        qty_zero;
   } cmd_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [9:0]  best_bid;
      logic        best_bid_valid;
      logic [9:0]  best_ask;
      logic        best_ask_valid;
      logic        crossed_book;
      logic [31:0] level_depth;
      logic [10:0] bid_level_count;
      logic [10:0] ask_level_count;
      logic [23:0] order_open_quantity;
   } rsp_type;

endpackage

// File: sv/lobt_front.sv
// Front stage: accept requests, clamp the price, classify and register the command.
module lobt_front #(
   parameter int PRICE_TICKS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              hold,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_action,
   input  logic [31:0]       req_order_id,
   input  logic              req_side,
   input  logic [9:0]        req_price,
   input  logic [23:0]       req_quantity,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output lobt_pkg::cmd_type cmd
);

   logic              valid_ff, valid_in;
   lobt_pkg::cmd_type cmd_ff, cmd_in;
   logic [9:0]        price_clamped;

   always_comb begin
      if (32'(req_price) >= PRICE_TICKS) begin
         price_clamped = 10'(PRICE_TICKS - 1);
      end else begin
         price_clamped = req_price;
      end
   end

   assign req_ready = (!valid_ff || cmd_ready) && !hold;

   always_comb begin
      valid_in = valid_ff && !cmd_ready;
      cmd_in   = cmd_ff;
      if (req_valid && req_ready) begin
         valid_in        = 1'b1;
         cmd_in.action   = req_action;
         cmd_in.order_id = req_order_id;
         cmd_in.side     = req_side;
         cmd_in.price    = price_clamped;
         cmd_in.quantity = req_quantity;
         cmd_in.qty_zero = (req_quantity == 24'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

endmodule

// File: sv/lobt_fifo.sv
// Two-entry command queue between the front and back stages.
module lobt_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  lobt_pkg::cmd_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output lobt_pkg::cmd_type out_data
);

   lobt_pkg::cmd_type mem_ff [2];
   logic              wr_ff, wr_in;
   logic              rd_ff, rd_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= in_data;
      end
   end

endmodule

// File: sv/lobt_back.sv
// Back stage: id search, order and depth memories, best price rescan, result register.
module lobt_back #(
   parameter int ORDER_SLOTS = 256,
   parameter int PRICE_TICKS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   output logic              clearing,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  lobt_pkg::cmd_type cmd,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lobt_pkg::rsp_type rsp
);

   localparam int SIW = $clog2(ORDER_SLOTS);
   localparam int SCW = $clog2(ORDER_SLOTS + 1);
   localparam int PW  = $clog2(PRICE_TICKS);
   localparam int CW  = $clog2(PRICE_TICKS + 1);
   localparam int DAW = PW + 1;
   localparam int DW  = 24 + SIW;
   localparam int SW  = (DW > 32) ? DW : 32;
   localparam int SLW = 32 + 1 + PW + 24;
   localparam int O_PRICE = 24;
   localparam int O_SIDE  = 24 + PW;
   localparam int O_KEY   = 25 + PW;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_EXEC  = 3'd3;
   localparam logic [2:0] ST_DRD   = 3'd4;
   localparam logic [2:0] ST_DWR   = 3'd5;
   localparam logic [2:0] ST_RSCAN = 3'd6;
   localparam logic [2:0] ST_FIN   = 3'd7;

   localparam logic [1:0] OP_ADD  = 2'd0;
   localparam logic [1:0] OP_SUB  = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   logic [2:0]             state_ff, state_in;
   lobt_pkg::cmd_type      cmd_ff, cmd_in;
   logic                   found_ff, found_in;
   logic [SIW-1:0]         slot_ff, slot_in;
   logic                   free_ok_ff, free_ok_in;
   logic [SIW-1:0]         free_ff, free_in;
   logic                   s_side_ff, s_side_in;
   logic [PW-1:0]          s_price_ff, s_price_in;
   logic [23:0]            s_open_ff, s_open_in;
   logic                   d_side_ff, d_side_in;
   logic [PW-1:0]          d_price_ff, d_price_in;
   logic [23:0]            d_amt_ff, d_amt_in;
   logic [1:0]             d_op_ff, d_op_in;
   logic [2:0]             status_ff, status_in;
   logic [DW-1:0]          depth_res_ff, depth_res_in;
   logic [23:0]            openq_ff, openq_in;
   logic [ORDER_SLOTS-1:0] valid_ff, valid_in;
   logic [PW-1:0]          bid_best_ff, bid_best_in, ask_best_ff, ask_best_in;
   logic                   bid_pres_ff, bid_pres_in, ask_pres_ff, ask_pres_in;
   logic [CW-1:0]          bid_lv_ff, bid_lv_in, ask_lv_ff, ask_lv_in;
   logic [SCW-1:0]         sc_iss_ff, sc_iss_in;
   logic [SIW-1:0]         sc_chk_ff, sc_chk_in;
   logic                   pend_ff, pend_in;
   logic                   rs_side_ff, rs_side_in;
   logic [CW-1:0]          rs_iss_ff, rs_iss_in;
   logic [CW-1:0]          rs_chk_ff, rs_chk_in;
   logic [DAW-1:0]         clr_ff, clr_in;
   lobt_pkg::rsp_type      rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [SLW-1:0]         slot_mem [ORDER_SLOTS];
   logic                   slot_we;
   logic [SIW-1:0]         slot_wa, slot_ra;
   logic [SLW-1:0]         slot_wd, slot_rd_ff;

   logic [DW-1:0]          dep_mem [2**DAW];
   logic                   dep_we;
   logic [DAW-1:0]         dep_wa, dep_ra;
   logic [DW-1:0]          dep_wd, dep_rd_ff;

   logic [PW-1:0]          cmd_price;
   logic [PW-1:0]          rs_iss_price, rs_chk_price;
   logic [DW-1:0]          dep_new;
   logic [SW-1:0]          depth_wide;

   assign cmd_price    = PW'(cmd_ff.price);
   assign rs_iss_price = rs_side_ff ? PW'(rs_iss_ff) : PW'(PRICE_TICKS - 1) - PW'(rs_iss_ff);
   assign rs_chk_price = rs_side_ff ? PW'(rs_chk_ff) : PW'(PRICE_TICKS - 1) - PW'(rs_chk_ff);
   assign slot_ra      = sc_iss_ff[SIW-1:0];
   assign dep_ra       = (state_ff == ST_RSCAN) ? {rs_side_ff, rs_iss_price}
                                                : {d_side_ff, d_price_ff};
   assign depth_wide   = SW'(depth_res_ff);
   assign clearing     = (state_ff == ST_CLEAR);
   assign cmd_ready    = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_wa] <= slot_wd;
      end
      slot_rd_ff <= slot_mem[slot_ra];
   end

   always_ff @(posedge clock) begin
      if (dep_we) begin
         dep_mem[dep_wa] <= dep_wd;
      end
      dep_rd_ff <= dep_mem[dep_ra];
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      found_in     = found_ff;
      slot_in      = slot_ff;
      free_ok_in   = free_ok_ff;
      free_in      = free_ff;
      s_side_in    = s_side_ff;
      s_price_in   = s_price_ff;
      s_open_in    = s_open_ff;
      d_side_in    = d_side_ff;
      d_price_in   = d_price_ff;
      d_amt_in     = d_amt_ff;
      d_op_in      = d_op_ff;
      status_in    = status_ff;
      depth_res_in = depth_res_ff;
      openq_in     = openq_ff;
      valid_in     = valid_ff;
      bid_best_in  = bid_best_ff;
      ask_best_in  = ask_best_ff;
      bid_pres_in  = bid_pres_ff;
      ask_pres_in  = ask_pres_ff;
      bid_lv_in    = bid_lv_ff;
      ask_lv_in    = ask_lv_ff;
      sc_iss_in    = sc_iss_ff;
      sc_chk_in    = sc_chk_ff;
      pend_in      = 1'b0;
      rs_side_in   = rs_side_ff;
      rs_iss_in    = rs_iss_ff;
      rs_chk_in    = rs_chk_ff;
      clr_in       = clr_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      slot_we      = 1'b0;
      slot_wa      = free_ff;
      slot_wd      = {cmd_ff.order_id, cmd_ff.side, cmd_price, cmd_ff.quantity};
      dep_we       = 1'b0;
      dep_wa       = {d_side_ff, d_price_ff};
      dep_wd       = '0;
      dep_new      = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            dep_we = 1'b1;
            dep_wa = clr_ff;
            clr_in = clr_ff + DAW'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_in       = cmd;
               found_in     = 1'b0;
               free_ok_in   = 1'b0;
               status_in    = lobt_pkg::STATUS_OK;
               openq_in     = 24'd0;
               depth_res_in = '0;
               sc_iss_in    = '0;
               if (cmd.action == lobt_pkg::ACT_INSERT && cmd.qty_zero) begin
                  status_in = lobt_pkg::STATUS_BAD_QTY;
                  state_in  = ST_FIN;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (sc_iss_ff < SCW'(ORDER_SLOTS)) begin
               sc_iss_in = sc_iss_ff + SCW'(1);
               sc_chk_in = sc_iss_ff[SIW-1:0];
               pend_in   = 1'b1;
            end
            if (pend_ff) begin
               if (valid_ff[sc_chk_ff] &&
                   slot_rd_ff[SLW-1:O_KEY] == cmd_ff.order_id) begin
                  found_in   = 1'b1;
                  slot_in    = sc_chk_ff;
                  s_side_in  = slot_rd_ff[O_SIDE];
                  s_price_in = slot_rd_ff[O_SIDE-1:O_PRICE];
                  s_open_in  = slot_rd_ff[23:0];
                  pend_in    = 1'b0;
                  state_in   = ST_EXEC;
               end else begin
                  if (!valid_ff[sc_chk_ff] && !free_ok_ff) begin
                     free_ok_in = 1'b1;
                     free_in    = sc_chk_ff;
                  end
                  if (sc_chk_ff == SIW'(ORDER_SLOTS - 1)) begin
                     pend_in  = 1'b0;
                     state_in = ST_EXEC;
                  end
               end
            end
         end
         ST_EXEC: begin
            state_in   = ST_DRD;
            d_side_in  = s_side_ff;
            d_price_in = s_price_ff;
            d_amt_in   = s_open_ff;
            d_op_in    = OP_SUB;
            unique case (cmd_ff.action)
               lobt_pkg::ACT_INSERT: begin
                  if (found_ff) begin
                     status_in = lobt_pkg::STATUS_DUP_ID;
                     state_in  = ST_FIN;
                  end else if (!free_ok_ff) begin
                     status_in = lobt_pkg::STATUS_FULL;
                     state_in  = ST_FIN;
                  end else begin
                     slot_we           = 1'b1;
                     valid_in[free_ff] = 1'b1;
                     d_side_in         = cmd_ff.side;
                     d_price_in        = cmd_price;
                     d_amt_in          = cmd_ff.quantity;
                     d_op_in           = OP_ADD;
                  end
               end
               lobt_pkg::ACT_CANCEL: begin
                  if (!found_ff) begin
                     status_in = lobt_pkg::STATUS_NOT_FOUND;
                     state_in  = ST_FIN;
                  end else begin
                     valid_in[slot_ff] = 1'b0;
                  end
               end
               lobt_pkg::ACT_FILL: begin
                  if (!found_ff) begin
                     status_in = lobt_pkg::STATUS_NOT_FOUND;
                     state_in  = ST_FIN;
                  end else if (cmd_ff.qty_zero || cmd_ff.quantity > s_open_ff) begin
                     status_in = lobt_pkg::STATUS_BAD_QTY;
                     state_in  = ST_FIN;
                  end else if (cmd_ff.quantity == s_open_ff) begin
                     valid_in[slot_ff] = 1'b0;
                  end else begin
                     slot_we  = 1'b1;
                     slot_wa  = slot_ff;
                     slot_wd  = {cmd_ff.order_id, s_side_ff, s_price_ff,
                                 s_open_ff - cmd_ff.quantity};
                     d_amt_in = cmd_ff.quantity;
                  end
               end
               lobt_pkg::ACT_QUERY: begin
                  status_in  = found_ff ? lobt_pkg::STATUS_OK : lobt_pkg::STATUS_NOT_FOUND;
                  openq_in   = found_ff ? s_open_ff : 24'd0;
                  d_side_in  = cmd_ff.side;
                  d_price_in = cmd_price;
                  d_op_in    = OP_READ;
               end
               default: begin
                  state_in = ST_FIN;
               end
            endcase
         end
         ST_DRD: begin
            state_in = ST_DWR;
         end
         ST_DWR: begin
            state_in = ST_FIN;
            unique case (d_op_ff)
               OP_ADD: begin
                  dep_we = 1'b1;
                  dep_wd = dep_rd_ff + DW'(d_amt_ff);
                  if (dep_rd_ff == '0) begin
                     if (!d_side_ff) begin
                        bid_lv_in = bid_lv_ff + CW'(1);
                        if (!bid_pres_ff || d_price_ff > bid_best_ff) begin
                           bid_pres_in = 1'b1;
                           bid_best_in = d_price_ff;
                        end
                     end else begin
                        ask_lv_in = ask_lv_ff + CW'(1);
                        if (!ask_pres_ff || d_price_ff < ask_best_ff) begin
                           ask_pres_in = 1'b1;
                           ask_best_in = d_price_ff;
                        end
                     end
                  end
               end
               OP_SUB: begin
                  dep_new = (dep_rd_ff >= DW'(d_amt_ff)) ? dep_rd_ff - DW'(d_amt_ff) : '0;
                  dep_we  = 1'b1;
                  dep_wd  = dep_new;
                  if (dep_new == '0) begin
                     rs_side_in = d_side_ff;
                     rs_iss_in  = '0;
                     if (!d_side_ff) begin
                        if (bid_lv_ff != '0) begin
                           bid_lv_in = bid_lv_ff - CW'(1);
                        end
                        if (d_price_ff == bid_best_ff) begin
                           bid_pres_in = 1'b0;
                           bid_best_in = '0;
                           state_in    = ST_RSCAN;
                        end
                     end else begin
                        if (ask_lv_ff != '0) begin
                           ask_lv_in = ask_lv_ff - CW'(1);
                        end
                        if (d_price_ff == ask_best_ff) begin
                           ask_pres_in = 1'b0;
                           ask_best_in = '0;
                           state_in    = ST_RSCAN;
                        end
                     end
                  end
               end
               OP_READ: begin
                  depth_res_in = dep_rd_ff;
               end
               default: begin
                  state_in = ST_FIN;
               end
            endcase
         end
         ST_RSCAN: begin
            if (rs_iss_ff < CW'(PRICE_TICKS)) begin
               rs_iss_in = rs_iss_ff + CW'(1);
               rs_chk_in = rs_iss_ff;
               pend_in   = 1'b1;
            end
            if (pend_ff) begin
               if (dep_rd_ff != '0) begin
                  if (!rs_side_ff) begin
                     bid_pres_in = 1'b1;
                     bid_best_in = rs_chk_price;
                  end else begin
                     ask_pres_in = 1'b1;
                     ask_best_in = rs_chk_price;
                  end
                  pend_in  = 1'b0;
                  state_in = ST_FIN;
               end else if (rs_chk_ff == CW'(PRICE_TICKS - 1)) begin
                  pend_in  = 1'b0;
                  state_in = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.status         = status_ff;
               rsp_in.best_bid       = bid_pres_ff ? 10'(bid_best_ff) : 10'd0;
               rsp_in.best_bid_valid = bid_pres_ff;
               rsp_in.best_ask       = ask_pres_ff ? 10'(ask_best_ff) : 10'd0;
               rsp_in.best_ask_valid = ask_pres_ff;
               rsp_in.crossed_book   = bid_pres_ff && ask_pres_ff &&
                                       (bid_best_ff >= ask_best_ff);
               rsp_in.level_depth    = (depth_wide > SW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                        : depth_wide[31:0];
               rsp_in.bid_level_count     = 11'(bid_lv_ff);
               rsp_in.ask_level_count     = 11'(ask_lv_ff);
               rsp_in.order_open_quantity = openq_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         valid_ff     <= '0;
         bid_best_ff  <= '0;
         ask_best_ff  <= '0;
         bid_pres_ff  <= 1'b0;
         ask_pres_ff  <= 1'b0;
         bid_lv_ff    <= '0;
         ask_lv_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         valid_ff     <= valid_in;
         bid_best_ff  <= bid_best_in;
         ask_best_ff  <= ask_best_in;
         bid_pres_ff  <= bid_pres_in;
         ask_pres_ff  <= ask_pres_in;
         bid_lv_ff    <= bid_lv_in;
         ask_lv_ff    <= ask_lv_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      found_ff     <= found_in;
      slot_ff      <= slot_in;
      free_ok_ff   <= free_ok_in;
      free_ff      <= free_in;
      s_side_ff    <= s_side_in;
      s_price_ff   <= s_price_in;
      s_open_ff    <= s_open_in;
      d_side_ff    <= d_side_in;
      d_price_ff   <= d_price_in;
      d_amt_ff     <= d_amt_in;
      d_op_ff      <= d_op_in;
      status_ff    <= status_in;
      depth_res_ff <= depth_res_in;
      openq_ff     <= openq_in;
      sc_iss_ff    <= sc_iss_in;
      sc_chk_ff    <= sc_chk_in;
      rs_side_ff   <= rs_side_in;
      rs_iss_ff    <= rs_iss_in;
      rs_chk_ff    <= rs_chk_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// File: sv/limit_order_book_table_core.sv
// Top level of the limit order book table: front stage, command queue, back stage.
// Each request is one insert, cancel, fill or query and returns exactly one response.
// The back stage finds an id by reading the order memory one slot per cycle, with an
// early exit on a match; an insert of zero quantity skips the search. When a fill or
// cancel empties the best bid or best ask level, the best price is rescanned through
// the depth memory read port, one tick per cycle. After reset the depth memory is
// cleared, one entry per cycle, over all 2 * 2**clog2(PRICE_TICKS) entries (2048 by
// default); no request is accepted during that pass. Up to three requests can be
// buffered ahead of the back stage, and a finished response waits in its own register.
module limit_order_book_table_core #(
   parameter int ORDER_SLOTS = 256,
   parameter int PRICE_TICKS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_order_id,
   input  logic        req_side,
   input  logic [9:0]  req_price,
   input  logic [23:0] req_quantity,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [9:0]  rsp_best_bid,
   output logic        rsp_best_bid_valid,
   output logic [9:0]  rsp_best_ask,
   output logic        rsp_best_ask_valid,
   output logic        rsp_crossed_book,
   output logic [31:0] rsp_level_depth,
   output logic [10:0] rsp_bid_level_count,
   output logic [10:0] rsp_ask_level_count,
   output logic [23:0] rsp_order_open_quantity
);

   logic              clearing;
   logic              f_valid, f_ready;
   lobt_pkg::cmd_type f_cmd;
   logic              q_valid, q_ready;
   lobt_pkg::cmd_type q_cmd;
   lobt_pkg::rsp_type rsp;

   lobt_front #(
      .PRICE_TICKS(PRICE_TICKS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .hold        (clearing),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_action  (req_action),
      .req_order_id(req_order_id),
      .req_side    (req_side),
      .req_price   (req_price),
      .req_quantity(req_quantity),
      .cmd_valid   (f_valid),
      .cmd_ready   (f_ready),
      .cmd         (f_cmd)
   );

   lobt_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .in_valid (f_valid),
      .in_ready (f_ready),
      .in_data  (f_cmd),
      .out_valid(q_valid),
      .out_ready(q_ready),
      .out_data (q_cmd)
   );

   lobt_back #(
      .ORDER_SLOTS(ORDER_SLOTS),
      .PRICE_TICKS(PRICE_TICKS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .clearing (clearing),
      .cmd_valid(q_valid),
      .cmd_ready(q_ready),
      .cmd      (q_cmd),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp      (rsp)
   );

   assign rsp_status              = rsp.status;
   assign rsp_best_bid            = rsp.best_bid;
   assign rsp_best_bid_valid      = rsp.best_bid_valid;
   assign rsp_best_ask            = rsp.best_ask;
   assign rsp_best_ask_valid      = rsp.best_ask_valid;
   assign rsp_crossed_book        = rsp.crossed_book;
   assign rsp_level_depth         = rsp.level_depth;
   assign rsp_bid_level_count     = rsp.bid_level_count;
   assign rsp_ask_level_count     = rsp.ask_level_count;
   assign rsp_order_open_quantity = rsp.order_open_quantity;

endmodule

// File: sv/lobt_checker.sv
// Port-level assertions for the limit order book table, bound to the top level.
module lobt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [9:0]  rsp_best_bid,
   input logic        rsp_best_bid_valid,
   input logic [9:0]  rsp_best_ask,
   input logic        rsp_best_ask_valid,
   input logic        rsp_crossed_book,
   input logic [23:0] rsp_order_open_quantity
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped or changed while stalled");

   a_empty_bid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_best_bid_valid |-> rsp_best_bid == 10'd0)
      else $error("best bid nonzero with no bid levels");

   a_empty_ask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_best_ask_valid |-> rsp_best_ask == 10'd0)
      else $error("best ask nonzero with no ask levels");

   a_crossed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_crossed_book |-> rsp_best_bid_valid && rsp_best_ask_valid &&
      rsp_best_bid >= rsp_best_ask)
      else $error("crossed flag without a crossed book");

   a_absent_qty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == lobt_pkg::STATUS_NOT_FOUND |->
      rsp_order_open_quantity == 24'd0)
      else $error("open quantity reported for an absent id");

endmodule

bind limit_order_book_table_core lobt_checker u_lobt_checker (.*);

// File: sim/tb_limit_order_book_table_core.sv
// Self-checking testbench for the limit order book table core.
module tb_limit_order_book_table_core;

   localparam int SLOTS = 256;
   localparam int TICKS = 1024;
   localparam int WATCHDOG = 20000;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] order_id;
      logic        side;
      logic [9:0]  price;
      logic [23:0] quantity;
   } order_msg_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_action;
   logic [31:0] req_order_id;
   logic        req_side;
   logic [9:0]  req_price;
   logic [23:0] req_quantity;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_status;
   logic [9:0]  rsp_best_bid;
   logic        rsp_best_bid_valid;
   logic [9:0]  rsp_best_ask;
   logic        rsp_best_ask_valid;
   logic        rsp_crossed_book;
   logic [31:0] rsp_level_depth;
   logic [10:0] rsp_bid_level_count;
   logic [10:0] rsp_ask_level_count;
   logic [23:0] rsp_order_open_quantity;
   logic        req_ready_seen;

   limit_order_book_table_core dut (.*);

   // book mirror
   logic        bk_valid [SLOTS];
   logic [31:0] bk_key [SLOTS];
   logic        bk_side [SLOTS];
   logic [9:0]  bk_price [SLOTS];
   logic [23:0] bk_open [SLOTS];
   logic [63:0] bid_sum [TICKS];
   logic [63:0] ask_sum [TICKS];
   logic [9:0]  top_bid, top_ask;
   logic        have_bid, have_ask;
   logic [10:0] n_bid, n_ask;

   order_msg_type     pending_orders[$];
   lobt_pkg::rsp_type expected_rsps[$];
   logic [31:0] live_ids[$];
   int  failures = 0;
   int  idle_pct = 28;
   int  quiet_cycles = 0;

   function automatic int lookup_id(logic [31:0] id);
      for (int i = 0; i < SLOTS; i++)
         if (bk_valid[i] && bk_key[i] == id) return i;
      return -1;
   endfunction

   function automatic void rescan_side(logic s);
      if (s == 1'b0) begin
         have_bid = 0;
         top_bid = '0;
         for (int p = TICKS - 1; p >= 0; p--)
            if (bid_sum[p] != 0) begin
               have_bid = 1;
               top_bid = p[9:0];
               break;
            end
      end else begin
         have_ask = 0;
         top_ask = '0;
         for (int p = 0; p < TICKS; p++)
            if (ask_sum[p] != 0) begin
               have_ask = 1;
               top_ask = p[9:0];
               break;
            end
      end
   endfunction

   function automatic void add_level(logic s, logic [9:0] p, logic [23:0] q);
      if (s == 1'b0) begin
         if (bid_sum[p] == 0) begin
            n_bid++;
            if (!have_bid || p > top_bid) begin
               have_bid = 1;
               top_bid = p;
            end
         end
         bid_sum[p] += q;
      end else begin
         if (ask_sum[p] == 0) begin
            n_ask++;
            if (!have_ask || p < top_ask) begin
               have_ask = 1;
               top_ask = p;
            end
         end
         ask_sum[p] += q;
      end
   endfunction

   function automatic void take_level(logic s, logic [9:0] p, logic [23:0] q);
      logic [63:0] d;
      d = (s == 1'b0) ? bid_sum[p] : ask_sum[p];
      d = (d >= q) ? d - q : 0;
      if (s == 1'b0) bid_sum[p] = d;
      else ask_sum[p] = d;
      if (d == 0) begin
         if (s == 1'b0) begin
            if (n_bid != 0) n_bid--;
            if (p == top_bid) rescan_side(0);
         end else begin
            if (n_ask != 0) n_ask--;
            if (p == top_ask) rescan_side(1);
         end
      end
   endfunction

   function automatic lobt_pkg::rsp_type apply_order(order_msg_type m);
      lobt_pkg::rsp_type r;
      int s;
      logic [63:0] d;
      r = '0;
      r.status = lobt_pkg::STATUS_OK;
      case (m.action)
         lobt_pkg::ACT_INSERT: begin
            if (m.quantity == 0) r.status = lobt_pkg::STATUS_BAD_QTY;
            else if (lookup_id(m.order_id) >= 0) r.status = lobt_pkg::STATUS_DUP_ID;
            else begin
               s = -1;
               for (int i = 0; i < SLOTS; i++)
                  if (!bk_valid[i]) begin
                     s = i;
                     break;
                  end
               if (s < 0) r.status = lobt_pkg::STATUS_FULL;
               else begin
                  bk_valid[s] = 1;
                  bk_key[s] = m.order_id;
                  bk_side[s] = m.side;
                  bk_price[s] = m.price;
                  bk_open[s] = m.quantity;
                  add_level(m.side, m.price, m.quantity);
               end
            end
         end
         lobt_pkg::ACT_CANCEL: begin
            s = lookup_id(m.order_id);
            if (s < 0) r.status = lobt_pkg::STATUS_NOT_FOUND;
            else begin
               take_level(bk_side[s], bk_price[s], bk_open[s]);
               bk_valid[s] = 0;
            end
         end
         lobt_pkg::ACT_FILL: begin
            s = lookup_id(m.order_id);
            if (s < 0) r.status = lobt_pkg::STATUS_NOT_FOUND;
            else if (m.quantity == 0 || m.quantity > bk_open[s])
               r.status = lobt_pkg::STATUS_BAD_QTY;
            else if (m.quantity == bk_open[s]) begin
               take_level(bk_side[s], bk_price[s], bk_open[s]);
               bk_valid[s] = 0;
            end else begin
               take_level(bk_side[s], bk_price[s], m.quantity);
               bk_open[s] -= m.quantity;
            end
         end
         default: begin
            d = (m.side == 1'b0) ? bid_sum[m.price] : ask_sum[m.price];
            r.level_depth = (d > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
            s = lookup_id(m.order_id);
            if (s < 0) r.status = lobt_pkg::STATUS_NOT_FOUND;
            else r.order_open_quantity = bk_open[s];
         end
      endcase
      r.best_bid = have_bid ? top_bid : '0;
      r.best_bid_valid = have_bid;
      r.best_ask = have_ask ? top_ask : '0;
      r.best_ask_valid = have_ask;
      r.crossed_book = have_bid && have_ask && top_bid >= top_ask;
      r.bid_level_count = n_bid;
      r.ask_level_count = n_ask;
      return r;
   endfunction

   function automatic logic [31:0] pick_id();
      if (live_ids.size() != 0 && $urandom_range(0, 9) < 8)
         return live_ids[$urandom_range(0, live_ids.size() - 1)];
      return $urandom_range(0, 3) == 0 ? $urandom() : 32'(1000 + $urandom_range(0, 400));
   endfunction

   task automatic push_order(logic [1:0] a, logic [31:0] id, logic sd,
                             logic [9:0] p, logic [23:0] q);
      order_msg_type m;
      m = '{action: a, order_id: id, side: sd, price: p, quantity: q};
      pending_orders.push_back(m);
      if (a == lobt_pkg::ACT_INSERT && q != 0) live_ids.push_back(id);
   endtask

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready_seen) begin
         if (pending_orders.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            order_msg_type m;
            m = pending_orders.pop_front();
            req_valid    <= 1'b1;
            req_action   <= m.action;
            req_order_id <= m.order_id;
            req_side     <= m.side;
            req_price    <= m.price;
            req_quantity <= m.quantity;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= reset ? 1'b0 : ($urandom_range(0, 99) >= idle_pct);
   end

   // response monitor
   always @(posedge clock) begin
      req_ready_seen <= !reset && req_valid && req_ready;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (req_valid && req_ready) begin
            order_msg_type m;
            m = '{action: req_action, order_id: req_order_id, side: req_side,
                  price: req_price, quantity: req_quantity};
            expected_rsps.push_back(apply_order(m));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected response");
               failures++;
            end else begin
               lobt_pkg::rsp_type e;
               e = expected_rsps.pop_front();
               if (rsp_status !== e.status) begin
                  $error("status exp %0d got %0d", e.status, rsp_status); failures++;
               end
               if (rsp_best_bid !== e.best_bid) begin
                  $error("best_bid exp %0d got %0d", e.best_bid, rsp_best_bid); failures++;
               end
               if (rsp_best_bid_valid !== e.best_bid_valid) begin
                  $error("best_bid_valid exp %0d got %0d", e.best_bid_valid,
                         rsp_best_bid_valid); failures++;
               end
               if (rsp_best_ask !== e.best_ask) begin
                  $error("best_ask exp %0d got %0d", e.best_ask, rsp_best_ask); failures++;
               end
               if (rsp_best_ask_valid !== e.best_ask_valid) begin
                  $error("best_ask_valid exp %0d got %0d", e.best_ask_valid,
                         rsp_best_ask_valid); failures++;
               end
               if (rsp_crossed_book !== e.crossed_book) begin
                  $error("crossed_book exp %0d got %0d", e.crossed_book,
                         rsp_crossed_book); failures++;
               end
               if (rsp_level_depth !== e.level_depth) begin
                  $error("level_depth exp %0d got %0d", e.level_depth,
                         rsp_level_depth); failures++;
               end
               if (rsp_bid_level_count !== e.bid_level_count) begin
                  $error("bid_level_count exp %0d got %0d", e.bid_level_count,
                         rsp_bid_level_count); failures++;
               end
               if (rsp_ask_level_count !== e.ask_level_count) begin
                  $error("ask_level_count exp %0d got %0d", e.ask_level_count,
                         rsp_ask_level_count); failures++;
               end
               if (rsp_order_open_quantity !== e.order_open_quantity) begin
                  $error("order_open_quantity exp %0d got %0d", e.order_open_quantity,
                         rsp_order_open_quantity); failures++;
               end
            end
         end
      end
   end

   // watchdog, allowing for the depth clear pass after reset
   always @(posedge clock) begin
      if (!reset && quiet_cycles > WATCHDOG) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int k;
      logic [1:0] a;
      reset = 1'b1;
      req_valid = 1'b0;
      req_ready_seen = 1'b0;
      rsp_ready = 1'b0;
      req_action = lobt_pkg::ACT_QUERY;
      req_order_id = '0;
      req_side = 1'b0;
      req_price = '0;
      req_quantity = '0;
      for (int i = 0; i < SLOTS; i++) bk_valid[i] = 0;
      for (int i = 0; i < TICKS; i++) begin
         bid_sum[i] = 0;
         ask_sum[i] = 0;
      end
      top_bid = 0; top_ask = 0; have_bid = 0; have_ask = 0; n_bid = 0; n_ask = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed
      push_order(lobt_pkg::ACT_QUERY, 32'h0, 1'b0, 10'd0, 24'd0);
      push_order(lobt_pkg::ACT_INSERT, 32'hFFFF_FFFF, 1'b0, 10'd1023, 24'hFFFFFF);
      push_order(lobt_pkg::ACT_INSERT, 32'h0, 1'b1, 10'd0, 24'd1);
      push_order(lobt_pkg::ACT_INSERT, 32'h5, 1'b1, 10'd500, 24'd0);
      push_order(lobt_pkg::ACT_INSERT, 32'h0, 1'b1, 10'd3, 24'd7);
      push_order(lobt_pkg::ACT_QUERY, 32'hFFFF_FFFF, 1'b0, 10'd1023, 24'd0);
      push_order(lobt_pkg::ACT_INSERT, 32'h10, 1'b0, 10'd200, 24'd50);
      push_order(lobt_pkg::ACT_INSERT, 32'h11, 1'b1, 10'd300, 24'd40);
      push_order(lobt_pkg::ACT_FILL, 32'h10, 1'b0, 10'd0, 24'd0);
      push_order(lobt_pkg::ACT_FILL, 32'h10, 1'b0, 10'd0, 24'd51);
      push_order(lobt_pkg::ACT_FILL, 32'h10, 1'b0, 10'd0, 24'd20);
      push_order(lobt_pkg::ACT_FILL, 32'h10, 1'b0, 10'd0, 24'd30);
      push_order(lobt_pkg::ACT_CANCEL, 32'h1234, 1'b0, 10'd0, 24'd0);
      push_order(lobt_pkg::ACT_FILL, 32'h1234, 1'b1, 10'd0, 24'd5);
      push_order(lobt_pkg::ACT_CANCEL, 32'hFFFF_FFFF, 1'b0, 10'd0, 24'd0);
      push_order(lobt_pkg::ACT_CANCEL, 32'h0, 1'b0, 10'd0, 24'd0);
      push_order(lobt_pkg::ACT_QUERY, 32'h11, 1'b1, 10'd300, 24'd0);
      push_order(lobt_pkg::ACT_CANCEL, 32'h11, 1'b0, 10'd0, 24'd0);
      // hold until the book drains
      wait (pending_orders.size() == 0 && expected_rsps.size() == 0);
      @(negedge clock);
      live_ids.delete();

      // fill the table to hit the full status, then clear it
      for (int i = 0; i < SLOTS + 2; i++)
         push_order(lobt_pkg::ACT_INSERT, 32'(5000 + i), i[0], 10'($urandom_range(0, 1023)),
                    24'($urandom_range(1, 100)));
      for (int i = 0; i < SLOTS; i++)
         push_order(lobt_pkg::ACT_CANCEL, 32'(5000 + i), 1'b0, 10'd0, 24'd0);
      live_ids.delete();

      // random, clustered around a narrow band so levels collide and cross
      for (k = 0; k < 100; k++) begin
         if (k == 30) begin
            idle_pct = 0;
            wait (pending_orders.size() == 0);
         end
         if (k == 70) begin
            idle_pct = 28;
            wait (pending_orders.size() == 0);
         end
         a = 2'($urandom_range(0, 3));
         if (a == lobt_pkg::ACT_INSERT && $urandom_range(0, 9) == 0)
            push_order(a, pick_id(), 1'($urandom), 10'($urandom), 24'($urandom));
         else
            push_order(a, a == lobt_pkg::ACT_INSERT ? 32'(1000 + $urandom_range(0, 400))
                                                    : pick_id(),
                       1'($urandom), 10'(500 + $urandom_range(0, 15)),
                       $urandom_range(0, 7) == 0 ? 24'($urandom_range(0, 2))
                                                 : 24'($urandom_range(1, 60)));
      end
      wait (pending_orders.size() == 0 && !req_valid);
      wait (expected_rsps.size() == 0);
      repeat (2 * (SLOTS + TICKS) + 20) @(posedge clock);
      if (failures == 0 && expected_rsps.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
